### rtl/sed_pkg.sv
// ----------------------------------------------------------------------------
// sed_pkg
// Shared types, constants and helpers of the script escape decoder.
// ----------------------------------------------------------------------------
package sed_pkg;

  localparam int MAX_TOKEN = 512;
  localparam int LEN_W     = $clog2(MAX_TOKEN);
  localparam int Q_DEPTH   = 4;
  localparam int Q_AW      = $clog2(Q_DEPTH);

  localparam logic [6:0] WAIT_RESET = 7'd15;
  localparam logic [6:0] WAIT_MAX   = 7'd99;

  localparam logic [2:0] REG_DEFAULT_WAIT = 3'd0;

  localparam logic [2:0] MODE_NORMAL = 3'd0;
  localparam logic [2:0] MODE_ESCAPE = 3'd1;
  localparam logic [2:0] MODE_OCTAL  = 3'd2;
  localparam logic [2:0] MODE_WAIT0  = 3'd3;
  localparam logic [2:0] MODE_WAIT1  = 3'd4;

  localparam logic [2:0] END_NUL   = 3'd0;
  localparam logic [2:0] END_DASH  = 3'd1;
  localparam logic [2:0] END_SPACE = 3'd2;
  localparam logic [2:0] END_DELAY = 3'd3;
  localparam logic [2:0] END_FULL  = 3'd4;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_Q     = 8'h71;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_W     = 8'h77;

  localparam logic [7:0] BYTE_LF    = 8'h0A;
  localparam logic [7:0] BYTE_CR    = 8'h0D;
  localparam logic [7:0] BYTE_TAB   = 8'h09;
  localparam logic [7:0] BYTE_BS    = 8'h08;
  localparam logic [7:0] BYTE_QMARK = 8'h3F;
  localparam logic [7:0] BYTE_SPACE = 8'h20;
  localparam logic [7:0] BYTE_XON   = 8'h11;

  typedef struct packed {
    logic             char_valid;
    logic [7:0]       out_char;
    logic             token_end;
    logic [2:0]       end_kind;
    logic             append_return;
    logic [6:0]       wait_seconds;
  } res_t;

  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } op_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             no_ret;
  } tok_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic logic tok_full(input tok_t t);
    return ({1'b0, t.len} + (LEN_W + 1)'(1)) >= (LEN_W + 1)'(MAX_TOKEN);
  endfunction

  function automatic res_t store_res(input tok_t t, input logic [7:0] b,
                                     input logic [6:0] w);
    res_t r;
    r.char_valid    = 1'b1;
    r.out_char      = b;
    r.token_end     = tok_full(t);
    r.end_kind      = tok_full(t) ? END_FULL : END_NUL;
    r.append_return = tok_full(t) & ~t.no_ret;
    r.wait_seconds  = w;
    return r;
  endfunction

  function automatic tok_t store_tok(input tok_t t);
    tok_t n;
    n = t;
    if (tok_full(t)) begin
      n = '0;
    end else begin
      n.len = t.len + LEN_W'(1);
    end
    return n;
  endfunction

  function automatic res_t finish_res(input logic [2:0] kind, input logic ret,
                                      input logic [6:0] w);
    res_t r;
    r.char_valid    = 1'b0;
    r.out_char      = 8'h00;
    r.token_end     = 1'b1;
    r.end_kind      = kind;
    r.append_return = ret;
    r.wait_seconds  = w;
    return r;
  endfunction

endpackage

### rtl/script_escape_decoder.sv
// ----------------------------------------------------------------------------
// script_escape_decoder
// Decodes tilde escapes of a script string into token bytes and token ends.
// ----------------------------------------------------------------------------
// One character is taken per clock while the four-entry operation queue has
// room. A character gives zero, one or two results; the output register
// presents one result per clock while pop is high, so a character with two
// results holds the result side until both are popped. Write default_wait
// only while the block is idle.
module script_escape_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  script_char,
  output logic        empty,
  input  logic        pop,
  output logic        char_valid,
  output logic [7:0]  out_char,
  output logic        token_end,
  output logic [2:0]  end_kind,
  output logic        append_return,
  output logic [6:0]  wait_seconds,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic           accept;
  logic [6:0]     default_wait;
  logic           reg_hit;
  logic           op_push;
  sed_pkg::op_t   op;
  sed_pkg::op_t   rd_op;
  logic           rd_en;
  logic           q_empty;
  sed_pkg::res_t  res;

  assign pready  = 1'b1;
  assign reg_hit = ({paddr[2], 2'b00} == sed_pkg::REG_DEFAULT_WAIT);
  assign prdata  = reg_hit ? {25'd0, default_wait} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_wait <= sed_pkg::WAIT_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      default_wait <= (pwdata[6:0] > sed_pkg::WAIT_MAX) ? sed_pkg::WAIT_MAX
                                                        : pwdata[6:0];
    end
  end

  assign accept = push && !full;

  sed_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .in_char      (script_char),
    .default_wait (default_wait),
    .op_push      (op_push),
    .op           (op)
  );

  sed_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (op_push),
    .wr_op   (op),
    .q_full  (full),
    .rd_en   (rd_en),
    .rd_op   (rd_op),
    .q_empty (q_empty)
  );

  sed_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .rd_op    (rd_op),
    .rd_en    (rd_en),
    .pop      (pop),
    .empty    (empty),
    .res      (res),
    .res_last (last)
  );

  assign char_valid    = res.char_valid;
  assign out_char      = res.out_char;
  assign token_end     = res.token_end;
  assign end_kind      = res.end_kind;
  assign append_return = res.append_return;
  assign wait_seconds  = res.wait_seconds;

endmodule

### rtl/sed_front.sv
// ----------------------------------------------------------------------------
// sed_front
// Classifies each script character against the parser state and builds one
// operation of up to two results.
// ----------------------------------------------------------------------------
module sed_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       in_char,
  input  logic [6:0]       default_wait,
  output logic             op_push,
  output sed_pkg::op_t     op
);

  logic [2:0]          mode;
  logic [2:0]          mode_next;
  logic [7:0]          octal;
  logic [7:0]          octal_next;
  logic [1:0]          digits;
  logic [1:0]          digits_next;
  logic [6:0]          wait_val;
  logic [6:0]          wait_next;
  sed_pkg::tok_t       tok;
  sed_pkg::tok_t       tok_next;

  logic                do_store;
  logic [7:0]          store_b;
  logic                do_fin;
  logic [2:0]          fin_kind;
  logic                fin_ret;
  logic                do_normal;
  logic [1:0]          digits_inc;
  logic [10:0]         wait_mul;
  sed_pkg::res_t       rr;
  logic [1:0]          n;

  always_comb begin
    mode_next   = mode;
    octal_next  = octal;
    digits_next = digits;
    wait_next   = wait_val;
    tok_next    = tok;
    do_store    = 1'b0;
    store_b     = 8'h00;
    do_fin      = 1'b0;
    fin_kind    = sed_pkg::END_NUL;
    fin_ret     = 1'b0;
    do_normal   = 1'b0;
    digits_inc  = digits + 2'd1;
    wait_mul    = 11'(wait_val) * 11'd10 + 11'(in_char[3:0]);
    rr          = '0;
    n           = 2'd0;
    op          = '0;

    case (mode)
      sed_pkg::MODE_ESCAPE: begin
        mode_next = sed_pkg::MODE_NORMAL;
        if (sed_pkg::is_digit(in_char)) begin
          octal_next  = {5'd0, in_char[2:0]};
          digits_next = 2'd1;
          mode_next   = sed_pkg::MODE_OCTAL;
        end else begin
          case (in_char)
            sed_pkg::CH_NUL: begin
              do_fin  = 1'b1;
              fin_ret = ~tok.no_ret;
            end
            sed_pkg::CH_N: begin do_store = 1'b1; store_b = sed_pkg::BYTE_LF;    end
            sed_pkg::CH_R: begin do_store = 1'b1; store_b = sed_pkg::BYTE_CR;    end
            sed_pkg::CH_T: begin do_store = 1'b1; store_b = sed_pkg::BYTE_TAB;   end
            sed_pkg::CH_B: begin do_store = 1'b1; store_b = sed_pkg::BYTE_BS;    end
            sed_pkg::CH_Q: begin do_store = 1'b1; store_b = sed_pkg::BYTE_QMARK; end
            sed_pkg::CH_S: begin do_store = 1'b1; store_b = sed_pkg::BYTE_SPACE; end
            sed_pkg::CH_X: begin do_store = 1'b1; store_b = sed_pkg::BYTE_XON;   end
            sed_pkg::CH_C: tok_next.no_ret = 1'b1;
            sed_pkg::CH_D: begin
              do_fin   = 1'b1;
              fin_kind = sed_pkg::END_DELAY;
            end
            sed_pkg::CH_W: begin
              wait_next = default_wait;
              mode_next = sed_pkg::MODE_WAIT0;
            end
            default: begin
              do_store = 1'b1;
              store_b  = in_char;
            end
          endcase
        end
      end
      sed_pkg::MODE_OCTAL: begin
        if (sed_pkg::is_digit(in_char)) begin
          octal_next  = {octal[4:0], in_char[2:0]};
          digits_next = digits_inc;
          if (digits_inc == 2'd3) begin
            mode_next   = sed_pkg::MODE_NORMAL;
            digits_next = 2'd0;
            do_store    = 1'b1;
            store_b     = {octal[4:0], in_char[2:0]};
          end
        end else begin
          digits_next = 2'd0;
          do_store    = 1'b1;
          store_b     = octal;
          do_normal   = 1'b1;
        end
      end
      sed_pkg::MODE_WAIT0: begin
        if (sed_pkg::is_digit(in_char)) begin
          wait_next = {3'd0, in_char[3:0]};
          mode_next = sed_pkg::MODE_WAIT1;
        end else begin
          do_normal = 1'b1;
        end
      end
      sed_pkg::MODE_WAIT1: begin
        if (sed_pkg::is_digit(in_char)) begin
          wait_next = wait_mul[6:0];
          mode_next = sed_pkg::MODE_NORMAL;
        end else begin
          do_normal = 1'b1;
        end
      end
      default: do_normal = 1'b1;
    endcase

    // first event: flush or escape result
    if (do_store) begin
      rr       = sed_pkg::store_res(tok_next, store_b, wait_next);
      tok_next = sed_pkg::store_tok(tok_next);
      op.r0    = rr;
      n        = 2'd1;
    end else if (do_fin) begin
      op.r0    = sed_pkg::finish_res(fin_kind, fin_ret, wait_next);
      tok_next = '0;
      n        = 2'd1;
    end

    // then the character itself as plain text
    if (do_normal) begin
      mode_next = sed_pkg::MODE_NORMAL;
      do_fin    = 1'b1;
      if (in_char == sed_pkg::CH_NUL) begin
        fin_kind = sed_pkg::END_NUL;
      end else if (in_char == sed_pkg::CH_DASH) begin
        fin_kind = sed_pkg::END_DASH;
      end else if (sed_pkg::is_space(in_char)) begin
        fin_kind = sed_pkg::END_SPACE;
      end else begin
        do_fin = 1'b0;
      end
      if (do_fin) begin
        rr       = sed_pkg::finish_res(fin_kind, ~tok_next.no_ret, wait_next);
        tok_next = '0;
      end else if (in_char == sed_pkg::CH_TILDE) begin
        mode_next = sed_pkg::MODE_ESCAPE;
      end else begin
        rr       = sed_pkg::store_res(tok_next, in_char, wait_next);
        tok_next = sed_pkg::store_tok(tok_next);
      end
      if (do_fin || in_char != sed_pkg::CH_TILDE) begin
        if (n == 2'd0) begin
          op.r0 = rr;
        end else begin
          op.r1 = rr;
        end
        n = n + 2'd1;
      end
    end

    op.two  = (n == 2'd2);
    op_push = accept && (n != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= sed_pkg::MODE_NORMAL;
      octal    <= 8'h00;
      digits   <= 2'd0;
      wait_val <= sed_pkg::WAIT_RESET;
      tok      <= '0;
    end else if (accept) begin
      mode     <= mode_next;
      octal    <= octal_next;
      digits   <= digits_next;
      wait_val <= wait_next;
      tok      <= tok_next;
    end
  end

endmodule

### rtl/sed_queue.sv
// ----------------------------------------------------------------------------
// sed_queue
// Short operation queue between the classifier and the result sequencer.
// ----------------------------------------------------------------------------
module sed_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  sed_pkg::op_t     wr_op,
  output logic             q_full,
  input  logic             rd_en,
  output sed_pkg::op_t     rd_op,
  output logic             q_empty
);

  sed_pkg::op_t              slots [sed_pkg::Q_DEPTH];
  logic [sed_pkg::Q_AW-1:0]  wr_ptr;
  logic [sed_pkg::Q_AW-1:0]  rd_ptr;
  logic [sed_pkg::Q_AW:0]    count;

  assign q_full  = (count == (sed_pkg::Q_AW + 1)'(sed_pkg::Q_DEPTH));
  assign q_empty = (count == '0);
  assign rd_op   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + sed_pkg::Q_AW'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + sed_pkg::Q_AW'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + (sed_pkg::Q_AW + 1)'(1);
      end else if (!wr_en && rd_en) begin
        count <= count - (sed_pkg::Q_AW + 1)'(1);
      end
    end
  end

endmodule

### rtl/sed_back.sv
// ----------------------------------------------------------------------------
// sed_back
// Result sequencer: takes one operation at a time and presents its results
// in order from an output register.
// ----------------------------------------------------------------------------
module sed_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  sed_pkg::op_t     rd_op,
  output logic             rd_en,
  input  logic             pop,
  output logic             empty,
  output sed_pkg::res_t    res,
  output logic             res_last
);

  logic          busy;
  logic          half;
  sed_pkg::op_t  cur;
  logic          done;

  assign empty    = ~busy;
  assign res      = half ? cur.r1 : cur.r0;
  assign res_last = ~cur.two | half;
  assign done     = busy && pop && res_last;
  assign rd_en    = !q_empty && (!busy || done);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      cur <= rd_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      half <= 1'b0;
    end else if (rd_en) begin
      busy <= 1'b1;
      half <= 1'b0;
    end else if (done) begin
      busy <= 1'b0;
      half <= 1'b0;
    end else if (busy && pop) begin
      half <= 1'b1;
    end
  end

endmodule

### rtl/sed_checker.sv
// ----------------------------------------------------------------------------
// sed_checker
// Port-level checks of the script escape decoder, bound to the top level.
// ----------------------------------------------------------------------------
module sed_checker (
  input logic        clk,
  input logic        rst,
  input logic        empty,
  input logic        pop,
  input logic        char_valid,
  input logic [7:0]  out_char,
  input logic        token_end,
  input logic [2:0]  end_kind,
  input logic        append_return,
  input logic [6:0]  wait_seconds,
  input logic        last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_char) && $stable(token_end)
                          && $stable(last)))
    else $error("result changed while stalled");

  a_byte: assert property (@(posedge clk) disable iff (rst)
    (!empty && !char_valid) |-> (out_char == 8'h00 && token_end))
    else $error("result carries neither byte nor token end");

  a_end: assert property (@(posedge clk) disable iff (rst)
    (!empty && !token_end) |-> (end_kind == sed_pkg::END_NUL && !append_return))
    else $error("token end fields set without token end");

  a_delay: assert property (@(posedge clk) disable iff (rst)
    (!empty && token_end && end_kind == sed_pkg::END_DELAY)
      |-> (!append_return && !char_valid))
    else $error("delay end with return or byte");

  a_wait: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (wait_seconds <= sed_pkg::WAIT_MAX && end_kind <= sed_pkg::END_FULL))
    else $error("wait or end kind out of range");

endmodule

bind script_escape_decoder sed_checker u_sed_checker (.*);

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives script characters into the escape decoder and checks every decoded
// byte and token end against a cycle-free decoder model kept in the bench.
// A directed table covers escapes, octal and wait digits, token ends and the
// tilde at end of string. Random tokens with random content follow, and one
// long token runs up to the size limit. Sender bursts, receiver stalls,
// default_wait writes between phases and read-back are all exercised.
// ----------------------------------------------------------------------------
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 500000;
  localparam int LONG_HOLD = 150;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS = 8;

  typedef struct packed {
    sed_pkg::res_t r;
    logic last;
  } decoded_t;

  typedef struct packed {
    logic [7:0]    ch;
    logic          typed;
    sed_pkg::res_t want;
  } script_step_t;

  localparam script_step_t DIRECTED_STEPS [24] = '{
    '{8'h41, 1'b1, '{1'b1, 8'h41, 1'b0, sed_pkg::END_NUL, 1'b0, 7'd15}},
    '{8'hFF, 1'b1, '{1'b1, 8'hFF, 1'b0, sed_pkg::END_NUL, 1'b0, 7'd15}},
    '{sed_pkg::CH_DASH, 1'b1, '{1'b0, 8'h00, 1'b1, sed_pkg::END_DASH, 1'b1, 7'd15}},
    '{sed_pkg::CH_TILDE, 1'b0, '0},
    '{sed_pkg::CH_C, 1'b0, '0},
    '{8'h20, 1'b1, '{1'b0, 8'h00, 1'b1, sed_pkg::END_SPACE, 1'b0, 7'd15}},
    '{sed_pkg::CH_TILDE, 1'b0, '0},
    '{sed_pkg::CH_D, 1'b1, '{1'b0, 8'h00, 1'b1, sed_pkg::END_DELAY, 1'b0, 7'd15}},
    '{sed_pkg::CH_TILDE, 1'b0, '0},
    '{8'h37, 1'b0, '0},
    '{8'h37, 1'b0, '0},
    '{8'h37, 1'b1, '{1'b1, 8'hFF, 1'b0, sed_pkg::END_NUL, 1'b0, 7'd15}},
    '{sed_pkg::CH_TILDE, 1'b0, '0},
    '{8'h39, 1'b0, '0},
    '{sed_pkg::CH_X, 1'b0, '0},
    '{sed_pkg::CH_TILDE, 1'b0, '0},
    '{sed_pkg::CH_W, 1'b0, '0},
    '{8'h39, 1'b0, '0},
    '{8'h39, 1'b0, '0},
    '{sed_pkg::CH_TILDE, 1'b0, '0},
    '{sed_pkg::CH_W, 1'b0, '0},
    '{sed_pkg::CH_DASH, 1'b1, '{1'b0, 8'h00, 1'b1, sed_pkg::END_DASH, 1'b1, 7'd15}},
    '{sed_pkg::CH_TILDE, 1'b0, '0},
    '{sed_pkg::CH_NUL, 1'b1, '{1'b0, 8'h00, 1'b1, sed_pkg::END_NUL, 1'b1, 7'd15}}
  };

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [7:0]  script_char;
  logic        empty;
  logic        pop;
  logic        char_valid;
  logic [7:0]  out_char;
  logic        token_end;
  logic [2:0]  end_kind;
  logic        append_return;
  logic [6:0]  wait_seconds;
  logic        last;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // decoder model state
  logic [2:0] scan_mode;
  logic [7:0] octal_acc;
  logic [1:0] octal_digits;
  logic       no_return;
  int         token_len;
  logic [6:0] wait_now;
  logic [6:0] wait_default;

  decoded_t step_items[$];
  decoded_t decoded_items[$];
  int mismatches;
  int items_sent;
  int full_tokens;
  int burst_left;
  int long_holds_asked;
  int long_holds_done;
  int cycles;

  script_escape_decoder uut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .script_char(script_char),
    .empty(empty),
    .pop(pop),
    .char_valid(char_valid),
    .out_char(out_char),
    .token_end(token_end),
    .end_kind(end_kind),
    .append_return(append_return),
    .wait_seconds(wait_seconds),
    .last(last),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic bit digit_char(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic bit blank_char(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic void emit_result(input logic v, input logic [7:0] ch, input logic e,
                                      input logic [2:0] kind, input logic ret);
    decoded_t d;
    d.r.char_valid    = v;
    d.r.out_char      = v ? ch : 8'h00;
    d.r.token_end     = e;
    d.r.end_kind      = e ? kind : sed_pkg::END_NUL;
    d.r.append_return = e ? ret : 1'b0;
    d.r.wait_seconds  = wait_now;
    d.last            = 1'b0;
    step_items.push_back(d);
  endfunction

  function automatic void close_token(input logic [2:0] kind, input logic ret);
    emit_result(1'b0, 8'h00, 1'b1, kind, ret);
    token_len = 0;
    no_return = 1'b0;
  endfunction

  function automatic void keep_byte(input logic [7:0] b);
    token_len++;
    if (token_len >= sed_pkg::MAX_TOKEN) begin
      emit_result(1'b1, b, 1'b1, sed_pkg::END_FULL, ~no_return);
      token_len = 0;
      no_return = 1'b0;
      full_tokens++;
    end else begin
      emit_result(1'b1, b, 1'b0, sed_pkg::END_NUL, 1'b0);
    end
  endfunction

  function automatic void plain_char(input logic [7:0] c);
    scan_mode = sed_pkg::MODE_NORMAL;
    if (c == sed_pkg::CH_NUL) begin
      close_token(sed_pkg::END_NUL, ~no_return);
    end else if (c == sed_pkg::CH_DASH) begin
      close_token(sed_pkg::END_DASH, ~no_return);
    end else if (blank_char(c)) begin
      close_token(sed_pkg::END_SPACE, ~no_return);
    end else if (c == sed_pkg::CH_TILDE) begin
      scan_mode = sed_pkg::MODE_ESCAPE;
    end else begin
      keep_byte(c);
    end
  endfunction

  function automatic void decode_char(input logic [7:0] c);
    step_items.delete();
    case (scan_mode)
      sed_pkg::MODE_ESCAPE: begin
        scan_mode = sed_pkg::MODE_NORMAL;
        if (digit_char(c)) begin
          octal_acc = {5'b0, c[2:0]};
          octal_digits = 2'd1;
          scan_mode = sed_pkg::MODE_OCTAL;
        end else begin
          case (c)
            sed_pkg::CH_NUL: close_token(sed_pkg::END_NUL, ~no_return);
            sed_pkg::CH_N: keep_byte(sed_pkg::BYTE_LF);
            sed_pkg::CH_R: keep_byte(sed_pkg::BYTE_CR);
            sed_pkg::CH_T: keep_byte(sed_pkg::BYTE_TAB);
            sed_pkg::CH_B: keep_byte(sed_pkg::BYTE_BS);
            sed_pkg::CH_Q: keep_byte(sed_pkg::BYTE_QMARK);
            sed_pkg::CH_S: keep_byte(sed_pkg::BYTE_SPACE);
            sed_pkg::CH_X: keep_byte(sed_pkg::BYTE_XON);
            sed_pkg::CH_C: no_return = 1'b1;
            sed_pkg::CH_D: close_token(sed_pkg::END_DELAY, 1'b0);
            sed_pkg::CH_W: begin
              wait_now = wait_default;
              scan_mode = sed_pkg::MODE_WAIT0;
            end
            default: keep_byte(c);
          endcase
        end
      end
      sed_pkg::MODE_OCTAL: begin
        if (digit_char(c)) begin
          octal_acc = {octal_acc[4:0], c[2:0]};
          octal_digits = octal_digits + 2'd1;
          if (octal_digits == 2'd3) begin
            scan_mode = sed_pkg::MODE_NORMAL;
            octal_digits = 2'd0;
            keep_byte(octal_acc);
          end
        end else begin
          octal_digits = 2'd0;
          keep_byte(octal_acc);
          plain_char(c);
        end
      end
      sed_pkg::MODE_WAIT0: begin
        if (digit_char(c)) begin
          wait_now = {3'b0, c[3:0]};
          scan_mode = sed_pkg::MODE_WAIT1;
        end else begin
          plain_char(c);
        end
      end
      sed_pkg::MODE_WAIT1: begin
        if (digit_char(c)) begin
          wait_now = 7'((int'(wait_now) * 10 + int'(c[3:0])) & 127);
          scan_mode = sed_pkg::MODE_NORMAL;
        end else begin
          plain_char(c);
        end
      end
      default: plain_char(c);
    endcase
    if (step_items.size() > 0) begin
      step_items[$].last = 1'b1;
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %0s: got 0x%0h, want 0x%0h (cycle %0d)", what, got, want, cycles);
    mismatches++;
  endtask

  // send one character; hold push high across a burst
  task automatic send_char(input logic [7:0] c, input bit typed = 1'b0,
                           input sed_pkg::res_t want = '0);
    int gap;
    decoded_t d;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    push <= 1'b1;
    script_char <= c;
    do @(posedge clk); while (full);
    items_sent++;
    decode_char(c);
    if (typed) begin
      d.r = want;
      d.last = 1'b1;
      decoded_items.push_back(d);
    end else begin
      foreach (step_items[i]) decoded_items.push_back(step_items[i]);
    end
    @(negedge clk);
  endtask

  task automatic wait_for_drain();
    push <= 1'b0;
    burst_left = 0;
    while (decoded_items.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic read_default_wait();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= sed_pkg::REG_DEFAULT_WAIT;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {25'b0, wait_default}) begin
      report_mismatch("default_wait read", prdata, {25'b0, wait_default});
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_default_wait(input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= sed_pkg::REG_DEFAULT_WAIT;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    wait_default = (value[6:0] > sed_pkg::WAIT_MAX) ? sed_pkg::WAIT_MAX : value[6:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    read_default_wait();
  endtask

  task automatic send_body_char();
    logic [7:0] ch;
    do ch = 8'($urandom_range(1, 255));
    while (blank_char(ch) || ch == sed_pkg::CH_DASH || ch == sed_pkg::CH_TILDE);
    send_char(ch);
  endtask

  // one token of random content; fill_up runs until a token hits the size limit
  task automatic send_token(input bit fill_up);
    int parts;
    int k;
    int pick;
    int start_full;
    logic [7:0] esc_letters [10];
    esc_letters = '{sed_pkg::CH_N, sed_pkg::CH_R, sed_pkg::CH_T, sed_pkg::CH_B,
                    sed_pkg::CH_Q, sed_pkg::CH_S, sed_pkg::CH_X, sed_pkg::CH_C,
                    8'h27, 8'h22};
    start_full = full_tokens;
    parts = $urandom_range(0, 6);
    k = 0;
    while (fill_up ? (full_tokens == start_full) : (k < parts)) begin
      k++;
      pick = $urandom_range(0, 9);
      if (fill_up && $urandom_range(0, 7) != 0) pick = 0;
      case (pick)
        4, 5: begin
          send_char(sed_pkg::CH_TILDE);
          if ($urandom_range(0, 4) == 0) send_char(8'($urandom_range(0, 255)));
          else send_char(esc_letters[$urandom_range(0, 9)]);
        end
        6: begin
          send_char(sed_pkg::CH_TILDE);
          repeat ($urandom_range(1, 3)) send_char(8'($urandom_range(8'h30, 8'h39)));
        end
        7: begin
          send_char(sed_pkg::CH_TILDE);
          send_char(sed_pkg::CH_W);
          repeat ($urandom_range(0, 2)) send_char(8'($urandom_range(8'h30, 8'h39)));
        end
        8: begin
          if (fill_up) begin
            send_body_char();
          end else begin
            send_char(sed_pkg::CH_TILDE);
            send_char(sed_pkg::CH_D);
          end
        end
        9: begin
          if (fill_up) begin
            send_body_char();
          end else begin
            repeat ($urandom_range(1, 3)) send_char(8'($urandom_range(0, 255)));
          end
        end
        default: send_body_char();
      endcase
    end
    case ($urandom_range(0, 3))
      0: send_char(sed_pkg::CH_NUL);
      1: send_char(sed_pkg::CH_DASH);
      2: send_char(($urandom_range(0, 5) == 0) ? 8'h20 : 8'($urandom_range(9, 13)));
      default: begin
        send_char(sed_pkg::CH_TILDE);
        send_char(sed_pkg::CH_NUL);
      end
    endcase
  endtask

  // receiver: a 16-bit stall pattern, reloaded when it wraps, plus requested long holds
  initial begin
    int hold_left;
    int pos;
    logic [15:0] stall_bits;
    hold_left = 0;
    pos = 0;
    stall_bits = '0;
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && long_holds_done < long_holds_asked) begin
        long_holds_done++;
        hold_left = LONG_HOLD;
      end
      if (pos == 0) begin
        stall_bits = ($urandom_range(0, 3) == 0) ? 16'h0 : 16'($urandom) & 16'($urandom);
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ~stall_bits[pos];
      end
      pos = (pos + 1) % 16;
    end
  end

  always @(posedge clk) begin
    decoded_t d;
    if (!rst && pop && !empty) begin
      if (decoded_items.size() == 0) begin
        report_mismatch("unexpected result", 32'({out_char, 7'b0, char_valid}), '0);
      end else begin
        d = decoded_items.pop_front();
        if (char_valid !== d.r.char_valid)
          report_mismatch("char_valid", 32'(char_valid), 32'(d.r.char_valid));
        if (out_char !== d.r.out_char)
          report_mismatch("out_char", 32'(out_char), 32'(d.r.out_char));
        if (token_end !== d.r.token_end)
          report_mismatch("token_end", 32'(token_end), 32'(d.r.token_end));
        if (end_kind !== d.r.end_kind)
          report_mismatch("end_kind", 32'(end_kind), 32'(d.r.end_kind));
        if (append_return !== d.r.append_return)
          report_mismatch("append_return", 32'(append_return), 32'(d.r.append_return));
        if (wait_seconds !== d.r.wait_seconds)
          report_mismatch("wait_seconds", 32'(wait_seconds), 32'(d.r.wait_seconds));
        if (last !== d.last)
          report_mismatch("last", 32'(last), 32'(d.last));
      end
    end
  end

  initial begin
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    logic [31:0] setting;
    rst = 1'b1;
    push = 1'b0;
    script_char = 8'h00;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mismatches = 0;
    items_sent = 0;
    full_tokens = 0;
    burst_left = 0;
    long_holds_asked = 0;
    long_holds_done = 0;
    scan_mode = sed_pkg::MODE_NORMAL;
    octal_acc = 8'h00;
    octal_digits = 2'd0;
    no_return = 1'b0;
    token_len = 0;
    wait_now = sed_pkg::WAIT_RESET;
    wait_default = sed_pkg::WAIT_RESET;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    read_default_wait();

    foreach (DIRECTED_STEPS[i]) begin
      send_char(DIRECTED_STEPS[i].ch, DIRECTED_STEPS[i].typed, DIRECTED_STEPS[i].want);
    end
    wait_for_drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: setting = 32'd0;
        1: setting = {25'b0, sed_pkg::WAIT_MAX};
        2: setting = 32'd100;
        3: setting = 32'hFFFF_FF85;
        4: setting = 32'h0000_007F;
        default: setting = $urandom;
      endcase
      write_default_wait(setting);
      if (phase == 1) long_holds_asked++;
      if (phase == 2) send_token(1'b1);
      setting = items_sent + PHASE_ITEMS;
      while (items_sent < int'(setting)) send_token(1'b0);
      wait_for_drain();
    end

    if (decoded_items.size() != 0) begin
      report_mismatch("results never seen", decoded_items.size(), 0);
    end
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/sed_pkg.sv
rtl/sed_front.sv
rtl/sed_queue.sv
rtl/sed_back.sv
rtl/script_escape_decoder.sv
rtl/sed_checker.sv
tb/sv/testbench.sv
